@@ rtl/core/node_transform_matrix_top_assert.svh @@
// Assertion macros shared by the node transform matrix RTL.
`ifndef NODE_TRANSFORM_MATRIX_TOP_ASSERT_SVH
`define NODE_TRANSFORM_MATRIX_TOP_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define NTM_IMPLIES(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("node transform: implication check failed");

// Signal stays within [lo, hi] whenever cond holds.
`define NTM_RANGE(label, cond, sig, lo, hi) \
   label: assert property (@(posedge clock) disable iff (reset) \
      (cond) |-> (((sig) >= (lo)) && ((sig) <= (hi)))) \
      else $error("node transform: range check failed");

`endif

@@ rtl/core/ntm_pkg.sv @@
// Package: types, constants and arithmetic helpers of the node transform matrix.
`timescale 1ns / 1ps
`default_nettype none
package ntm_pkg;

   localparam int FRAC_BITS_DEFAULT = 16;

   // Angle constants in Q3.12 radians
   localparam int TURN_Q12    = 25736;
   localparam int QUARTER_Q12 = 6434;
   localparam int EIGHTH_Q12  = 3217;

   localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

   // Reciprocals for exact floor division of values below 2^31:
   // floor(t/d) = (t * ceil(2^k/d)) >> k, with k = 31 + ceil(log2 d)
   localparam int SHIFT_72 = 38;
   localparam int SHIFT_42 = 37;
   localparam int SHIFT_20 = 36;
   localparam int SHIFT_6  = 34;
   localparam int SHIFT_56 = 37;
   localparam int SHIFT_30 = 36;
   localparam int SHIFT_12 = 35;
   localparam logic [32:0] RECIP_72 = 33'(((64'd1 << SHIFT_72) + 64'd71) / 64'd72);
   localparam logic [32:0] RECIP_42 = 33'(((64'd1 << SHIFT_42) + 64'd41) / 64'd42);
   localparam logic [32:0] RECIP_20 = 33'(((64'd1 << SHIFT_20) + 64'd19) / 64'd20);
   localparam logic [32:0] RECIP_6  = 33'(((64'd1 << SHIFT_6) + 64'd5) / 64'd6);
   localparam logic [32:0] RECIP_56 = 33'(((64'd1 << SHIFT_56) + 64'd55) / 64'd56);
   localparam logic [32:0] RECIP_30 = 33'(((64'd1 << SHIFT_30) + 64'd29) / 64'd30);
   localparam logic [32:0] RECIP_12 = 33'(((64'd1 << SHIFT_12) + 64'd11) / 64'd12);

   // Pipeline depths
   localparam int TRIG_LAT  = 11;
   localparam int ROT_LAT   = 2;
   localparam int SCALE_LAT = 2;
   localparam int TOTAL_LAT = TRIG_LAT + ROT_LAT + SCALE_LAT;

   typedef enum logic [1:0] {
      QUAD_FIRST,
      QUAD_SECOND,
      QUAD_THIRD,
      QUAD_FOURTH
   } quad_type;

   typedef struct packed {
      logic [11:0] x;
      quad_type    quad;
      logic        swap;
   } trig_meta_type;

   typedef struct packed {
      logic signed [31:0] s;
      logic signed [31:0] c;
   } trig_type;

   typedef struct packed {
      logic signed [32:0] m11;
      logic signed [32:0] m12;
      logic signed [32:0] m13;
      logic signed [32:0] m21;
      logic signed [32:0] m22;
      logic signed [32:0] m23;
      logic signed [32:0] m31;
      logic signed [32:0] m32;
      logic signed [32:0] m33;
   } rot_type;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
   } vec_type;

   typedef struct packed {
      vec_type pos;
      vec_type scale;
      vec_type anchor;
   } node_type;

   // Unsigned Q2.30 product, rounded half up
   function automatic logic [30:0] umul30(input logic [29:0] a, input logic [30:0] b);
      logic [61:0] p;
      p = 62'(a) * 62'(b) + (62'd1 << 29);
      return 31'(p >> 30);
   endfunction

   // floor(t / d) by reciprocal multiply
   function automatic logic [30:0] recip_div(input logic [30:0] t, input logic [32:0] m,
                                             input logic [5:0] k);
      logic [63:0] p;
      p = 64'(t) * 64'(m);
      return 31'(p >> k);
   endfunction

   // Signed Q2.30 product, rounded half up
   function automatic logic signed [31:0] mul30s(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
      logic signed [63:0] p;
      p = 64'(a) * 64'(b) + (64'sd1 <<< 29);
      return 32'(p >>> 30);
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
      logic signed [64:0] hi;
      logic signed [64:0] lo;
      hi = 65'sd2147483647;
      lo = -65'sd2147483648;
      if (v > hi) begin
         return 32'sh7fff_ffff;
      end else if (v < lo) begin
         return 32'sh8000_0000;
      end
      return 32'(v);
   endfunction

endpackage
`default_nettype wire

@@ rtl/core/ntm_sincos.sv @@
// Pipelined sine/cosine of one Q3.12 angle, Q2.30 results.
`timescale 1ns / 1ps
`default_nettype none
module ntm_sincos (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   input  wire logic signed [15:0] angle,
   output ntm_pkg::trig_type       trig,
   output logic                    out_valid
);

   localparam int N = ntm_pkg::TRIG_LAT;
   localparam logic signed [16:0] TURN_S = 17'(ntm_pkg::TURN_Q12);
   localparam logic [14:0] Q1 = 15'(ntm_pkg::QUARTER_Q12);
   localparam logic [14:0] Q2 = 15'(2 * ntm_pkg::QUARTER_Q12);
   localparam logic [14:0] Q3 = 15'(3 * ntm_pkg::QUARTER_Q12);
   localparam logic [30:0] ONE = ntm_pkg::ONE_Q30;

   logic [N-1:0]            vld_ff;
   ntm_pkg::trig_meta_type  meta_ff [1:N-1];
   logic [29:0]             x2_ff [2:7];
   logic [30:0]             ts_a_ff, tc_a_ff, ps_a_ff, pc_a_ff;
   logic [30:0]             ts_b_ff, tc_b_ff, ps_b_ff, pc_b_ff;
   logic [30:0]             ts_c_ff, tc_c_ff, ps_c_ff, pc_c_ff;
   logic [30:0]             ts_d_ff, tc_d_ff, sin_u_ff, cos_u_ff;
   ntm_pkg::trig_type       trig_ff, trig_in;

   logic signed [16:0]      a_mod;
   logic [14:0]             a_pos;
   logic [12:0]             r_raw;
   ntm_pkg::trig_meta_type  meta_in;
   logic [23:0]             sq;
   logic signed [31:0]      s_sel, c_sel;

   // Stage 1: wrap into one turn, split into quadrant and folded remainder
   always_comb begin
      a_mod = 17'(angle);
      if (a_mod < 17'sd0) a_mod = a_mod + TURN_S;
      if (a_mod < 17'sd0) a_mod = a_mod + TURN_S;
      if (a_mod >= TURN_S) a_mod = a_mod - TURN_S;
      a_pos = a_mod[14:0];
      priority if (a_pos >= Q3) begin
         meta_in.quad = ntm_pkg::QUAD_FOURTH;
         r_raw = 13'(a_pos - Q3);
      end else if (a_pos >= Q2) begin
         meta_in.quad = ntm_pkg::QUAD_THIRD;
         r_raw = 13'(a_pos - Q2);
      end else if (a_pos >= Q1) begin
         meta_in.quad = ntm_pkg::QUAD_SECOND;
         r_raw = 13'(a_pos - Q1);
      end else begin
         meta_in.quad = ntm_pkg::QUAD_FIRST;
         r_raw = 13'(a_pos);
      end
      if (r_raw > 13'(ntm_pkg::EIGHTH_Q12)) begin
         meta_in.x    = 12'(13'(ntm_pkg::QUARTER_Q12) - r_raw);
         meta_in.swap = 1'b1;
      end else begin
         meta_in.x    = r_raw[11:0];
         meta_in.swap = 1'b0;
      end
   end

   // x = r << 18 in Q2.30, so x*x rounds exactly to r*r << 6
   assign sq = 24'(meta_ff[1].x) * 24'(meta_ff[1].x);

   always_comb begin
      s_sel = meta_ff[N-1].swap ? 32'({1'b0, cos_u_ff}) : 32'({1'b0, sin_u_ff});
      c_sel = meta_ff[N-1].swap ? 32'({1'b0, sin_u_ff}) : 32'({1'b0, cos_u_ff});
      unique case (meta_ff[N-1].quad)
         ntm_pkg::QUAD_FIRST: begin
            trig_in.s = s_sel;
            trig_in.c = c_sel;
         end
         ntm_pkg::QUAD_SECOND: begin
            trig_in.s = c_sel;
            trig_in.c = -s_sel;
         end
         ntm_pkg::QUAD_THIRD: begin
            trig_in.s = -s_sel;
            trig_in.c = -c_sel;
         end
         default: begin
            trig_in.s = -c_sel;
            trig_in.c = s_sel;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[N-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      meta_ff[1] <= meta_in;
      for (int i = 2; i < N; i++) begin
         meta_ff[i] <= meta_ff[i-1];
      end
      x2_ff[2] <= {sq, 6'b0};
      for (int i = 3; i < 8; i++) begin
         x2_ff[i] <= x2_ff[i-1];
      end
      // Horner steps: divide, then multiply by x2, alternating stages
      ts_a_ff <= ONE - ntm_pkg::recip_div(31'(x2_ff[2]), ntm_pkg::RECIP_72,
                                          6'(ntm_pkg::SHIFT_72));
      tc_a_ff <= ONE - ntm_pkg::recip_div(31'(x2_ff[2]), ntm_pkg::RECIP_56,
                                          6'(ntm_pkg::SHIFT_56));
      ps_a_ff <= ntm_pkg::umul30(x2_ff[3], ts_a_ff);
      pc_a_ff <= ntm_pkg::umul30(x2_ff[3], tc_a_ff);
      ts_b_ff <= ONE - ntm_pkg::recip_div(ps_a_ff, ntm_pkg::RECIP_42, 6'(ntm_pkg::SHIFT_42));
      tc_b_ff <= ONE - ntm_pkg::recip_div(pc_a_ff, ntm_pkg::RECIP_30, 6'(ntm_pkg::SHIFT_30));
      ps_b_ff <= ntm_pkg::umul30(x2_ff[5], ts_b_ff);
      pc_b_ff <= ntm_pkg::umul30(x2_ff[5], tc_b_ff);
      ts_c_ff <= ONE - ntm_pkg::recip_div(ps_b_ff, ntm_pkg::RECIP_20, 6'(ntm_pkg::SHIFT_20));
      tc_c_ff <= ONE - ntm_pkg::recip_div(pc_b_ff, ntm_pkg::RECIP_12, 6'(ntm_pkg::SHIFT_12));
      ps_c_ff <= ntm_pkg::umul30(x2_ff[7], ts_c_ff);
      pc_c_ff <= ntm_pkg::umul30(x2_ff[7], tc_c_ff);
      ts_d_ff <= ONE - ntm_pkg::recip_div(ps_c_ff, ntm_pkg::RECIP_6, 6'(ntm_pkg::SHIFT_6));
      tc_d_ff <= ONE - (pc_c_ff >> 1);
      sin_u_ff <= ntm_pkg::umul30({meta_ff[9].x, 18'b0}, ts_d_ff);
      cos_u_ff <= tc_d_ff;
      trig_ff  <= trig_in;
   end

   assign trig      = trig_ff;
   assign out_valid = vld_ff[N-1];

endmodule
`default_nettype wire

@@ rtl/core/ntm_rotate.sv @@
// Two-stage Z-Y-Z rotation matrix from three sine/cosine pairs.
`timescale 1ns / 1ps
`default_nettype none
module ntm_rotate (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   input  ntm_pkg::trig_type      trig_a,
   input  ntm_pkg::trig_type      trig_b,
   input  ntm_pkg::trig_type      trig_c,
   output ntm_pkg::rot_type       rot,
   output logic                   out_valid
);

   logic [1:0]          vld_ff;
   logic signed [31:0]  cacb_ff, sacb_ff, sasc_ff, sacc_ff, casb_ff;
   logic signed [31:0]  casc_ff, cacc_ff, sasb_ff, sbcc_ff, sbsc_ff;
   logic signed [31:0]  sc_ff, cc_ff, cb_ff;
   ntm_pkg::rot_type    rot_ff, rot_in;

   always_comb begin
      rot_in.m11 = 33'(ntm_pkg::mul30s(cacb_ff, cc_ff)) - 33'(sasc_ff);
      rot_in.m12 = -33'(ntm_pkg::mul30s(cacb_ff, sc_ff)) - 33'(sacc_ff);
      rot_in.m13 = 33'(casb_ff);
      rot_in.m21 = 33'(ntm_pkg::mul30s(sacb_ff, cc_ff)) + 33'(casc_ff);
      rot_in.m22 = -33'(ntm_pkg::mul30s(sacb_ff, sc_ff)) + 33'(cacc_ff);
      rot_in.m23 = 33'(sasb_ff);
      rot_in.m31 = -33'(sbcc_ff);
      rot_in.m32 = 33'(sbsc_ff);
      rot_in.m33 = 33'(cb_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      cacb_ff <= ntm_pkg::mul30s(trig_a.c, trig_b.c);
      sacb_ff <= ntm_pkg::mul30s(trig_a.s, trig_b.c);
      sasc_ff <= ntm_pkg::mul30s(trig_a.s, trig_c.s);
      sacc_ff <= ntm_pkg::mul30s(trig_a.s, trig_c.c);
      casb_ff <= ntm_pkg::mul30s(trig_a.c, trig_b.s);
      casc_ff <= ntm_pkg::mul30s(trig_a.c, trig_c.s);
      cacc_ff <= ntm_pkg::mul30s(trig_a.c, trig_c.c);
      sasb_ff <= ntm_pkg::mul30s(trig_a.s, trig_b.s);
      sbcc_ff <= ntm_pkg::mul30s(trig_b.s, trig_c.c);
      sbsc_ff <= ntm_pkg::mul30s(trig_b.s, trig_c.s);
      sc_ff   <= trig_c.s;
      cc_ff   <= trig_c.c;
      cb_ff   <= trig_b.c;
      rot_ff  <= rot_in;
   end

   assign rot       = rot_ff;
   assign out_valid = vld_ff[1];

endmodule
`default_nettype wire

@@ rtl/core/ntm_scale.sv @@
// Column scaling, translation and saturation: multiply stage, then round stage.
`timescale 1ns / 1ps
`default_nettype none
module ntm_scale #(
   parameter int FRAC_BITS = ntm_pkg::FRAC_BITS_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   input  ntm_pkg::rot_type        rot,
   input  ntm_pkg::node_type       node,
   output logic signed [31:0]      rot_out [9],
   output logic signed [31:0]      tr_out [3],
   output logic                    out_valid
);

   localparam logic signed [63:0] TR_HALF  = 64'sd1 <<< (FRAC_BITS - 1);
   localparam logic signed [64:0] ROT_HALF = 65'sd1 <<< 29;

   logic [1:0]          vld_ff;
   logic signed [32:0]  m_arr [9];
   logic signed [31:0]  k_arr [3];
   logic signed [31:0]  p_arr [3];
   logic signed [31:0]  a_arr [3];
   logic signed [64:0]  pr_ff [9];
   logic signed [63:0]  tp_ff [3];
   logic signed [31:0]  pos_ff [3];
   logic signed [31:0]  rot_ff [9];
   logic signed [31:0]  tr_ff [3];
   logic signed [63:0]  tr_round [3];

   assign m_arr[0] = rot.m11;
   assign m_arr[1] = rot.m12;
   assign m_arr[2] = rot.m13;
   assign m_arr[3] = rot.m21;
   assign m_arr[4] = rot.m22;
   assign m_arr[5] = rot.m23;
   assign m_arr[6] = rot.m31;
   assign m_arr[7] = rot.m32;
   assign m_arr[8] = rot.m33;
   assign k_arr[0] = node.scale.x;
   assign k_arr[1] = node.scale.y;
   assign k_arr[2] = node.scale.z;
   assign a_arr[0] = node.anchor.x;
   assign a_arr[1] = node.anchor.y;
   assign a_arr[2] = node.anchor.z;
   assign p_arr[0] = node.pos.x;
   assign p_arr[1] = node.pos.y;
   assign p_arr[2] = node.pos.z;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         tr_round[i] = (tp_ff[i] + TR_HALF) >>> FRAC_BITS;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      // column j of every row takes scale component j
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            pr_ff[r*3+c] <= 65'(m_arr[r*3+c]) * 65'(k_arr[c]);
         end
      end
      for (int i = 0; i < 3; i++) begin
         tp_ff[i]  <= 64'(k_arr[i]) * 64'(a_arr[i]);
         pos_ff[i] <= p_arr[i];
      end
      for (int i = 0; i < 9; i++) begin
         rot_ff[i] <= ntm_pkg::sat32((pr_ff[i] + ROT_HALF) >>> 30);
      end
      for (int i = 0; i < 3; i++) begin
         tr_ff[i] <= ntm_pkg::sat32(65'(pos_ff[i]) - 65'(tr_round[i]));
      end
   end

   assign rot_out   = rot_ff;
   assign tr_out    = tr_ff;
   assign out_valid = vld_ff[1];

endmodule
`default_nettype wire

@@ rtl/core/node_transform_matrix_top.sv @@
// Top level of the node transform matrix pipeline.
`timescale 1ns / 1ps
`default_nettype none
// Computes the scaled Z-Y-Z rotation and the translation column of one scene
// node's model matrix. A request word is taken in every cycle that start is
// high; busy is always low. The response word appears on the rsp_ ports,
// marked by rsp_valid for one cycle, once its request has passed the
// sine/cosine pipelines, the rotation products and the scaling and rounding
// stages. Responses cannot be held off, so the receiver must take every word
// in the cycle it is shown. Throughput is one word per cycle.
`include "node_transform_matrix_top_assert.svh"
module node_transform_matrix_top #(
   parameter int FRAC_BITS = ntm_pkg::FRAC_BITS_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic signed [31:0] req_pos_x,
   input  wire logic signed [31:0] req_pos_y,
   input  wire logic signed [31:0] req_pos_z,
   input  wire logic signed [15:0] req_angle_first,
   input  wire logic signed [15:0] req_angle_second,
   input  wire logic signed [15:0] req_angle_third,
   input  wire logic signed [31:0] req_scale_x,
   input  wire logic signed [31:0] req_scale_y,
   input  wire logic signed [31:0] req_scale_z,
   input  wire logic signed [31:0] req_anchor_x,
   input  wire logic signed [31:0] req_anchor_y,
   input  wire logic signed [31:0] req_anchor_z,
   output logic                    rsp_valid,
   output logic signed [31:0]      rsp_r11,
   output logic signed [31:0]      rsp_r12,
   output logic signed [31:0]      rsp_r13,
   output logic signed [31:0]      rsp_r21,
   output logic signed [31:0]      rsp_r22,
   output logic signed [31:0]      rsp_r23,
   output logic signed [31:0]      rsp_r31,
   output logic signed [31:0]      rsp_r32,
   output logic signed [31:0]      rsp_r33,
   output logic signed [31:0]      rsp_tr_x,
   output logic signed [31:0]      rsp_tr_y,
   output logic signed [31:0]      rsp_tr_z
);

   localparam int DLY = ntm_pkg::TRIG_LAT + ntm_pkg::ROT_LAT;
   localparam logic signed [31:0] ONE_S = 32'sd1073741824;

   logic               accept;
   logic [2:0]         trig_valid;
   ntm_pkg::trig_type  trig_a, trig_b, trig_c;
   logic               rot_valid;
   ntm_pkg::rot_type   rot;
   ntm_pkg::node_type  node_in;
   ntm_pkg::node_type  node_dly_ff [DLY];
   logic signed [31:0] rot_out [9];
   logic signed [31:0] tr_out [3];

   assign busy   = 1'b0;
   assign accept = start && !busy;

   assign node_in.pos.x    = req_pos_x;
   assign node_in.pos.y    = req_pos_y;
   assign node_in.pos.z    = req_pos_z;
   assign node_in.scale.x  = req_scale_x;
   assign node_in.scale.y  = req_scale_y;
   assign node_in.scale.z  = req_scale_z;
   assign node_in.anchor.x = req_anchor_x;
   assign node_in.anchor.y = req_anchor_y;
   assign node_in.anchor.z = req_anchor_z;

   // position, scale and anchor ride alongside the trig and rotation stages
   always_ff @(posedge clock) begin
      node_dly_ff[0] <= node_in;
      for (int i = 1; i < DLY; i++) begin
         node_dly_ff[i] <= node_dly_ff[i-1];
      end
   end

   ntm_sincos u_sincos_a (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .angle     (req_angle_first),
      .trig      (trig_a),
      .out_valid (trig_valid[0])
   );

   ntm_sincos u_sincos_b (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .angle     (req_angle_second),
      .trig      (trig_b),
      .out_valid (trig_valid[1])
   );

   ntm_sincos u_sincos_c (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .angle     (req_angle_third),
      .trig      (trig_c),
      .out_valid (trig_valid[2])
   );

   ntm_rotate u_rotate (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (trig_valid[0]),
      .trig_a    (trig_a),
      .trig_b    (trig_b),
      .trig_c    (trig_c),
      .rot       (rot),
      .out_valid (rot_valid)
   );

   ntm_scale #(
      .FRAC_BITS (FRAC_BITS)
   ) u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rot_valid),
      .rot       (rot),
      .node      (node_dly_ff[DLY-1]),
      .rot_out   (rot_out),
      .tr_out    (tr_out),
      .out_valid (rsp_valid)
   );

   assign rsp_r11  = rot_out[0];
   assign rsp_r12  = rot_out[1];
   assign rsp_r13  = rot_out[2];
   assign rsp_r21  = rot_out[3];
   assign rsp_r22  = rot_out[4];
   assign rsp_r23  = rot_out[5];
   assign rsp_r31  = rot_out[6];
   assign rsp_r32  = rot_out[7];
   assign rsp_r33  = rot_out[8];
   assign rsp_tr_x = tr_out[0];
   assign rsp_tr_y = tr_out[1];
   assign rsp_tr_z = tr_out[2];

   `NTM_IMPLIES(a_trig_lanes_agree, trig_valid[0], trig_valid[1] && trig_valid[2])
   `NTM_IMPLIES(a_rsp_follows_rot, rsp_valid, $past(rot_valid, ntm_pkg::SCALE_LAT))
   `NTM_IMPLIES(a_rsp_had_request, rsp_valid, $past(start, ntm_pkg::TOTAL_LAT))
   `NTM_RANGE(a_sin_bounded, trig_valid[1], trig_b.s, -ONE_S, ONE_S)
   `NTM_RANGE(a_cos_bounded, trig_valid[1], trig_b.c, -ONE_S, ONE_S)

endmodule
`default_nettype wire

@@ dv/tb_node_transform_matrix_top.sv @@
// Testbench for node_transform_matrix_top: self-checking against a built-in matrix predictor.
`timescale 1ns / 1ps
module tb_node_transform_matrix_top;

   typedef logic [11:0][31:0] matrix_word_type;
   typedef struct {
      logic [2:0][31:0] pos;
      logic [2:0][15:0] ang;
      logic [2:0][31:0] scale;
      logic [2:0][31:0] anchor;
   } node_word_type;

   localparam int MAX_REPORTS = 10;
   localparam int DRAIN_CYCLES = ntm_pkg::TOTAL_LAT + 10;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [31:0] req_pos_x = '0, req_pos_y = '0, req_pos_z = '0;
   logic signed [15:0] req_angle_first = '0, req_angle_second = '0, req_angle_third = '0;
   logic signed [31:0] req_scale_x = '0, req_scale_y = '0, req_scale_z = '0;
   logic signed [31:0] req_anchor_x = '0, req_anchor_y = '0, req_anchor_z = '0;
   logic rsp_valid;
   logic signed [31:0] rsp_r11, rsp_r12, rsp_r13, rsp_r21, rsp_r22, rsp_r23;
   logic signed [31:0] rsp_r31, rsp_r32, rsp_r33, rsp_tr_x, rsp_tr_y, rsp_tr_z;

   matrix_word_type pending_matrices[$];
   int mismatch_count = 0;
   int stray_count = 0;
   int words_sent = 0;
   int words_checked = 0;

   always #4 clock = ~clock;

   node_transform_matrix_top i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_pos_x(req_pos_x), .req_pos_y(req_pos_y), .req_pos_z(req_pos_z),
      .req_angle_first(req_angle_first), .req_angle_second(req_angle_second),
      .req_angle_third(req_angle_third),
      .req_scale_x(req_scale_x), .req_scale_y(req_scale_y), .req_scale_z(req_scale_z),
      .req_anchor_x(req_anchor_x), .req_anchor_y(req_anchor_y),
      .req_anchor_z(req_anchor_z),
      .rsp_valid(rsp_valid),
      .rsp_r11(rsp_r11), .rsp_r12(rsp_r12), .rsp_r13(rsp_r13),
      .rsp_r21(rsp_r21), .rsp_r22(rsp_r22), .rsp_r23(rsp_r23),
      .rsp_r31(rsp_r31), .rsp_r32(rsp_r32), .rsp_r33(rsp_r33),
      .rsp_tr_x(rsp_tr_x), .rsp_tr_y(rsp_tr_y), .rsp_tr_z(rsp_tr_z)
   );

   // ---------------- predictor ----------------
   function automatic longint unsigned uq30_mul(longint unsigned a, longint unsigned b);
      return (a * b + (64'd1 << 29)) >> 30;
   endfunction

   function automatic longint round_shift(longint v, int n);
      return (v + (64'sd1 <<< (n - 1))) >>> n;
   endfunction

   function automatic logic [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) return 32'h7fff_ffff;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return v[31:0];
   endfunction

   function automatic void sine_cosine(input logic [15:0] ang, output longint s_o,
                                       output longint c_o);
      longint a, q, r, s, c;
      longint unsigned x, x2, ts, tc, one;
      bit swapped;
      one = 64'd1 << 30;
      swapped = 1'b0;
      a = longint'($signed(ang)) % ntm_pkg::TURN_Q12;
      if (a < 0) a += ntm_pkg::TURN_Q12;
      q = a / ntm_pkg::QUARTER_Q12;
      r = a - q * ntm_pkg::QUARTER_Q12;
      if (r > ntm_pkg::EIGHTH_Q12) begin
         r = ntm_pkg::QUARTER_Q12 - r;
         swapped = 1'b1;
      end
      x = longint'(r) << 18;
      x2 = uq30_mul(x, x);
      ts = one - x2 / 72;
      ts = one - uq30_mul(x2, ts) / 42;
      ts = one - uq30_mul(x2, ts) / 20;
      ts = one - uq30_mul(x2, ts) / 6;
      ts = uq30_mul(x, ts);
      tc = one - x2 / 56;
      tc = one - uq30_mul(x2, tc) / 30;
      tc = one - uq30_mul(x2, tc) / 12;
      tc = one - uq30_mul(x2, tc) / 2;
      s = swapped ? longint'(tc) : longint'(ts);
      c = swapped ? longint'(ts) : longint'(tc);
      case (q)
         longint'(ntm_pkg::QUAD_FIRST): begin s_o = s;  c_o = c;  end
         longint'(ntm_pkg::QUAD_SECOND): begin s_o = c;  c_o = -s; end
         longint'(ntm_pkg::QUAD_THIRD): begin s_o = -s; c_o = -c; end
         default: begin s_o = -c; c_o = s; end
      endcase
   endfunction

   function automatic longint q30_mul(longint a, longint b);
      return round_shift(a * b, 30);
   endfunction

   function automatic matrix_word_type model_matrix(node_word_type n);
      longint sa, ca, sb, cb, sc, cc, cacb, sacb, prod;
      longint m[9];
      longint k[3];
      matrix_word_type res;
      sine_cosine(n.ang[0], sa, ca);
      sine_cosine(n.ang[1], sb, cb);
      sine_cosine(n.ang[2], sc, cc);
      cacb = q30_mul(ca, cb);
      sacb = q30_mul(sa, cb);
      m[0] = q30_mul(cacb, cc) - q30_mul(sa, sc);
      m[1] = -q30_mul(cacb, sc) - q30_mul(sa, cc);
      m[2] = q30_mul(ca, sb);
      m[3] = q30_mul(sacb, cc) + q30_mul(ca, sc);
      m[4] = -q30_mul(sacb, sc) + q30_mul(ca, cc);
      m[5] = q30_mul(sa, sb);
      m[6] = -q30_mul(sb, cc);
      m[7] = q30_mul(sb, sc);
      m[8] = cb;
      for (int i = 0; i < 3; i++) k[i] = longint'($signed(n.scale[i]));
      for (int i = 0; i < 9; i++) res[i] = clamp32(round_shift(m[i] * k[i % 3], 30));
      for (int i = 0; i < 3; i++) begin
         prod = round_shift(k[i] * longint'($signed(n.anchor[i])),
                            ntm_pkg::FRAC_BITS_DEFAULT);
         res[9 + i] = clamp32(longint'($signed(n.pos[i])) - prod);
      end
      return res;
   endfunction

   // ---------------- driver ----------------
   task automatic send_node(node_word_type n, int gap);
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start <= 1'b1;
      {req_pos_x, req_pos_y, req_pos_z} <= {n.pos[0], n.pos[1], n.pos[2]};
      {req_angle_first, req_angle_second, req_angle_third} <= {n.ang[0], n.ang[1], n.ang[2]};
      {req_scale_x, req_scale_y, req_scale_z} <= {n.scale[0], n.scale[1], n.scale[2]};
      {req_anchor_x, req_anchor_y, req_anchor_z} <= {n.anchor[0], n.anchor[1], n.anchor[2]};
      do @(posedge clock); while (busy);
      pending_matrices.push_back(model_matrix(n));
      words_sent++;
   endtask

   task automatic wait_drained();
      while (pending_matrices.size() != 0) @(posedge clock);
   endtask

   function automatic node_word_type random_node();
      node_word_type n;
      for (int i = 0; i < 3; i++) begin
         n.pos[i] = $urandom;
         n.ang[i] = $urandom;
         n.anchor[i] = $urandom;
         case ($urandom_range(0, 3))
            0: n.scale[i] = $urandom;                              // often saturates
            1: n.scale[i] = 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
            default: n.scale[i] = 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
         endcase
         if ($urandom_range(0, 7) == 0) n.anchor[i] = '0;
      end
      return n;
   endfunction

   // ---------------- checker ----------------
   always @(posedge clock) begin
      matrix_word_type want, got;
      if (!reset && rsp_valid) begin
         got = {rsp_tr_z, rsp_tr_y, rsp_tr_x, rsp_r33, rsp_r32, rsp_r31,
                rsp_r23, rsp_r22, rsp_r21, rsp_r13, rsp_r12, rsp_r11};
         if (pending_matrices.size() == 0) begin
            stray_count++;
            $display("ERROR: unexpected response word at %0t", $realtime);
         end else begin
            want = pending_matrices.pop_front();
            words_checked++;
            for (int i = 0; i < 12; i++) begin
               if (got[i] !== want[i]) begin
                  mismatch_count++;
                  if (mismatch_count <= MAX_REPORTS)
                     $display("ERROR: word %0d field %0d expected %h got %h",
                              words_checked, i, want[i], got[i]);
               end
            end
         end
      end
   end

   // ---------------- tests ----------------
   task automatic test_directed();
      node_word_type n;
      logic [15:0] angs[14];
      angs = '{16'd0, 16'd3217, 16'd3218, 16'd6434, 16'd12868, 16'd19302, 16'd25735,
               16'd25736, 16'hffff, 16'h7fff, 16'h8000, 16'd6433, 16'd1, 16'd9651};
      foreach (angs[i]) begin
         n.pos = {32'd0, 32'h0001_0000, -32'sd65536};
         n.ang = {angs[i], angs[(i + 3) % 14], angs[(i + 7) % 14]};
         n.scale = {32'h0001_0000, 32'h0002_0000, 32'hffff_0000};
         n.anchor = {32'h0000_8000, 32'd0, 32'h0003_0000};
         send_node(n, i % 3);
      end
      // saturating scales, extreme positions and anchors
      n.ang = '0;
      n.pos = {32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff};
      n.scale = {32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff};
      n.anchor = {32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff};
      send_node(n, 0);
      n.pos = {32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000};
      n.anchor = {32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000};
      n.ang = {16'h8000, 16'h7fff, 16'h8000};
      send_node(n, 0);
      n = '{default: '0};
      send_node(n, 1);
      n.pos = {32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff};
      n.scale = {32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff};
      n.anchor = {32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff};
      n.ang = {16'hffff, 16'hffff, 16'hffff};
      send_node(n, 0);
   endtask

   task automatic test_random(int count);
      bit burst;
      for (int i = 0; i < count; i++) begin
         if (i % 100 == 0) burst = ($urandom_range(0, 2) == 0);
         send_node(random_node(), burst ? 0 : $urandom_range(0, 17));
      end
   endtask

   task automatic test_pause_until_drained();
      for (int i = 0; i < 20; i++) send_node(random_node(), 0);
      @(negedge clock);
      start <= 1'b0;
      wait_drained();
      for (int i = 0; i < 20; i++) send_node(random_node(), $urandom_range(0, 2));
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_pause_until_drained();
      test_random(2000);
      @(negedge clock);
      start <= 1'b0;
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d node words, checked %0d matrices (directed angles, saturation,",
               words_sent, words_checked);
      $display("random fields with bursts and idle gaps, one full drain pause).");
      if (mismatch_count == 0 && stray_count == 0 && pending_matrices.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("ERROR: timeout");
      $display("DONE: errors detected");
      $finish;
   end
endmodule
